>>> src/ocb_pkg.sv
// Package for the OHLC candle builder: shared widths, defaults and
// controller/datapath handshake structs. No dependencies.
package ocb_pkg;

    localparam int PRICE_BITS_DEF = 40;
    localparam int COUNT_BITS_DEF = 24;
    localparam int TS_W           = 64;
    localparam int PX_W           = 40;
    localparam int AMT_W          = 32;
    localparam int VOL_W          = 48;
    localparam int LEN_W          = 48;
    localparam int OCNT_W         = 24;
    localparam int SUM_W          = 64;
    localparam logic [LEN_W-1:0] LEN_RESET = 48'd60000000;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic start_div;
        logic load_out;
    } ocb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit;
        logic div_done;
    } ocb_sts_t;

endpackage

>>> src/ohlc_candle_builder_core.sv
// Top level of the OHLC candle builder: controller plus datapath.
// Depends on ocb_pkg, ocb_ctrl, ocb_datapath, ocb_div.
//
// Channel   Signals                               Direction
// -------   -----------------------------------   ---------
// in        in_valid/in_ready, mode..amount        sink
// out       out_valid/out_ready, candle_start..    source
// cfg       cfg_valid/cfg_ready, cfg_data          sink
//
// A trade that stays in its candle, or a flush with no candle open, goes
// through without holding the input. A transaction that closes a candle holds
// the input while two bit-serial dividers form the side averages, then loads
// the output register; a stalled output holds the next emission only. Reset is
// asynchronous and clears all candle state; candle_length returns to 60000000.
module ohlc_candle_builder_core
    import ocb_pkg::*;
#(
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [TS_W-1:0]   timestamp,
    input  logic              is_buy,
    input  logic [PX_W-1:0]   price,
    input  logic [AMT_W-1:0]  amount,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TS_W-1:0]   candle_start,
    output logic [PX_W-1:0]   px_open,
    output logic [PX_W-1:0]   px_high,
    output logic [PX_W-1:0]   px_low,
    output logic [PX_W-1:0]   px_close,
    output logic [PX_W-1:0]   buy_avg_px,
    output logic [PX_W-1:0]   sell_avg_px,
    output logic [VOL_W-1:0]  buy_volume,
    output logic [VOL_W-1:0]  sell_volume,
    output logic [OCNT_W-1:0] buy_trades,
    output logic [OCNT_W-1:0] sell_trades
);

    ocb_cmd_t cmd;
    ocb_sts_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    ocb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ocb_datapath #(
        .PRICE_BITS (PRICE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .timestamp    (timestamp),
        .is_buy       (is_buy),
        .price        (price),
        .amount       (amount),
        .candle_start (candle_start),
        .px_open      (px_open),
        .px_high      (px_high),
        .px_low       (px_low),
        .px_close     (px_close),
        .buy_avg_px   (buy_avg_px),
        .sell_avg_px  (sell_avg_px),
        .buy_volume   (buy_volume),
        .sell_volume  (sell_volume),
        .buy_trades   (buy_trades),
        .sell_trades  (sell_trades)
    );

endmodule

>>> src/ocb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ocb_pkg.
module ocb_div
    import ocb_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SUM_W-1:0]      dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic [SUM_W-1:0]      quotient,
    output logic                  busy
);

    logic [SUM_W-1:0]      dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [6:0]            cnt_reg, cnt_next;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  qbit;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
        qbit     = (rem_sh >= {1'b0, dsr_reg});
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = 7'(SUM_W);
        end
        else if (cnt_reg != 7'd0)
        begin
            // shift in one dividend bit, subtract when it fits
            rem_next = qbit ? COUNT_BITS'(rem_sh - {1'b0, dsr_reg}) : COUNT_BITS'(rem_sh);
            dvd_next = {dvd_reg[SUM_W-2:0], qbit};
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dvd_reg;
    assign busy     = (cnt_reg != 7'd0);

endmodule

>>> src/ocb_ctrl.sv
// Controller for the candle builder: transaction sequencing and output valid.
// Depends on ocb_pkg.
module ocb_ctrl
    import ocb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  ocb_sts_t sts,
    output ocb_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    always_comb
    begin
        out_free      = !out_valid_reg || out_ready;
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.start_div = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && sts.emit)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                        state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/ocb_datapath.sv
// Datapath for the candle builder: candle state, emission snapshot, two
// dividers for the side averages, output registers. Depends on ocb_pkg, ocb_div.
module ocb_datapath
    import ocb_pkg::*;
#(
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ocb_cmd_t          cmd,
    output ocb_sts_t          sts,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              mode,
    input  logic [TS_W-1:0]   timestamp,
    input  logic              is_buy,
    input  logic [PX_W-1:0]   price,
    input  logic [AMT_W-1:0]  amount,
    output logic [TS_W-1:0]   candle_start,
    output logic [PX_W-1:0]   px_open,
    output logic [PX_W-1:0]   px_high,
    output logic [PX_W-1:0]   px_low,
    output logic [PX_W-1:0]   px_close,
    output logic [PX_W-1:0]   buy_avg_px,
    output logic [PX_W-1:0]   sell_avg_px,
    output logic [VOL_W-1:0]  buy_volume,
    output logic [VOL_W-1:0]  sell_volume,
    output logic [OCNT_W-1:0] buy_trades,
    output logic [OCNT_W-1:0] sell_trades
);

    localparam int PW = PRICE_BITS;
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CNT_MAX = '1;

    logic [LEN_W-1:0] len_reg;
    logic             active_reg, active_next;
    logic [TS_W-1:0]  start_reg, start_next, end_reg, end_next;
    logic [PW-1:0]    first_reg, first_next, max_reg, max_next;
    logic [PW-1:0]    min_reg, min_next, last_reg, last_next;
    logic [CW-1:0]    bcnt_reg, bcnt_next, scnt_reg, scnt_next;
    logic [SUM_W-1:0] bsum_reg, bsum_next, ssum_reg, ssum_next;
    logic [VOL_W-1:0] bvol_reg, bvol_next, svol_reg, svol_next;

    // snapshot of the candle being emitted
    logic [TS_W-1:0]  s_start_reg;
    logic [PW-1:0]    s_first_reg, s_max_reg, s_min_reg, s_last_reg;
    logic [CW-1:0]    s_bcnt_reg, s_scnt_reg;
    logic [VOL_W-1:0] s_bvol_reg, s_svol_reg;

    logic [PW-1:0]    px;
    logic             late, opening, fresh;
    logic [TS_W:0]    e1_raw, e2_raw;
    logic [TS_W-1:0]  e1, open_t;
    logic [PW-1:0]    b_first, b_max, b_min;
    logic [CW-1:0]    b_bcnt, b_scnt;
    logic [SUM_W-1:0] b_bsum, b_ssum;
    logic [VOL_W-1:0] b_bvol, b_svol;
    logic [SUM_W:0]   sum_add;
    logic [VOL_W:0]   vol_add;
    logic [SUM_W-1:0] q_buy, q_sell;
    logic             busy_buy, busy_sell;

    always_comb
    begin
        px      = PW'(price);
        late    = active_reg && (timestamp > end_reg);
        opening = !active_reg || late;
        e1_raw  = {1'b0, end_reg} + {{(TS_W+1-LEN_W){1'b0}}, len_reg};
        e1      = e1_raw[TS_W] ? '1 : e1_raw[TS_W-1:0];
        open_t  = (!active_reg || timestamp > e1) ? timestamp : end_reg;
        e2_raw  = {1'b0, open_t} + {{(TS_W+1-LEN_W){1'b0}}, len_reg};

        sts.emit     = mode ? active_reg : late;
        sts.div_done = !busy_buy && !busy_sell;

        b_first = opening ? '0 : first_reg;
        b_max   = opening ? '0 : max_reg;
        b_min   = opening ? '0 : min_reg;
        b_bcnt  = opening ? '0 : bcnt_reg;
        b_scnt  = opening ? '0 : scnt_reg;
        b_bsum  = opening ? '0 : bsum_reg;
        b_ssum  = opening ? '0 : ssum_reg;
        b_bvol  = opening ? '0 : bvol_reg;
        b_svol  = opening ? '0 : svol_reg;
        // no trade yet in this candle: a count is nonzero after any trade
        fresh   = (b_bcnt == '0) && (b_scnt == '0);

        sum_add = {1'b0, (is_buy ? b_bsum : b_ssum)} + {{(SUM_W+1-PW){1'b0}}, px};
        vol_add = {1'b0, (is_buy ? b_bvol : b_svol)} + {{(VOL_W+1-AMT_W){1'b0}}, amount};

        active_next = active_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        first_next  = first_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        last_next   = last_reg;
        bcnt_next   = bcnt_reg;
        scnt_next   = scnt_reg;
        bsum_next   = bsum_reg;
        ssum_next   = ssum_reg;
        bvol_next   = bvol_reg;
        svol_next   = svol_reg;

        if (cmd.accept)
        begin
            if (mode)
                active_next = 1'b0;
            else
            begin
                active_next = 1'b1;
                if (opening)
                begin
                    start_next = open_t;
                    end_next   = e2_raw[TS_W] ? '1 : e2_raw[TS_W-1:0];
                end
                first_next = fresh ? px : b_first;
                max_next   = (fresh || px > b_max) ? px : b_max;
                min_next   = (fresh || px < b_min) ? px : b_min;
                last_next  = px;
                bcnt_next  = b_bcnt;
                scnt_next  = b_scnt;
                bsum_next  = b_bsum;
                ssum_next  = b_ssum;
                bvol_next  = b_bvol;
                svol_next  = b_svol;
                if (is_buy)
                begin
                    bcnt_next = (b_bcnt == CNT_MAX) ? b_bcnt : b_bcnt + CW'(1);
                    bsum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    bvol_next = vol_add[VOL_W] ? '1 : vol_add[VOL_W-1:0];
                end
                else
                begin
                    scnt_next = (b_scnt == CNT_MAX) ? b_scnt : b_scnt + CW'(1);
                    ssum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    svol_next = vol_add[VOL_W] ? '1 : vol_add[VOL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_RESET;
            active_reg <= 1'b0;
            start_reg  <= '0;
            end_reg    <= '0;
            first_reg  <= '0;
            max_reg    <= '0;
            min_reg    <= '0;
            last_reg   <= '0;
            bcnt_reg   <= '0;
            scnt_reg   <= '0;
            bsum_reg   <= '0;
            ssum_reg   <= '0;
            bvol_reg   <= '0;
            svol_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_data;
            active_reg <= active_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            first_reg  <= first_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
            last_reg   <= last_next;
            bcnt_reg   <= bcnt_next;
            scnt_reg   <= scnt_next;
            bsum_reg   <= bsum_next;
            ssum_reg   <= ssum_next;
            bvol_reg   <= bvol_next;
            svol_reg   <= svol_next;
        end
    end

    // capture the finished candle while the live state moves on
    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            s_start_reg <= start_reg;
            s_first_reg <= first_reg;
            s_max_reg   <= max_reg;
            s_min_reg   <= min_reg;
            s_last_reg  <= last_reg;
            s_bcnt_reg  <= bcnt_reg;
            s_scnt_reg  <= scnt_reg;
            s_bvol_reg  <= bvol_reg;
            s_svol_reg  <= svol_reg;
        end
    end

    ocb_div #(.COUNT_BITS(CW)) u_div_buy (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (bsum_reg),
        .divisor  (bcnt_reg),
        .quotient (q_buy),
        .busy     (busy_buy)
    );

    ocb_div #(.COUNT_BITS(CW)) u_div_sell (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (ssum_reg),
        .divisor  (scnt_reg),
        .quotient (q_sell),
        .busy     (busy_sell)
    );

    function automatic logic [PX_W-1:0] avg_px(input logic [SUM_W-1:0] q,
                                               input logic [CW-1:0] c);
        logic [SUM_W-1:0] qc;
        begin
            qc = ((q >> PW) != '0) ? SUM_W'({PW{1'b1}}) : q;
            avg_px = (c == '0) ? '0 : PX_W'(qc);
        end
    endfunction

    function automatic logic [OCNT_W-1:0] out_cnt(input logic [CW-1:0] c);
        begin
            out_cnt = (SUM_W'(c) > SUM_W'({OCNT_W{1'b1}})) ? '1 : OCNT_W'(c);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            candle_start <= s_start_reg;
            px_open      <= PX_W'(s_first_reg);
            px_high      <= PX_W'(s_max_reg);
            px_low       <= PX_W'(s_min_reg);
            px_close     <= PX_W'(s_last_reg);
            buy_avg_px   <= avg_px(q_buy, s_bcnt_reg);
            sell_avg_px  <= avg_px(q_sell, s_scnt_reg);
            buy_volume   <= s_bvol_reg;
            sell_volume  <= s_svol_reg;
            buy_trades   <= out_cnt(s_bcnt_reg);
            sell_trades  <= out_cnt(s_scnt_reg);
        end
    end

endmodule
